// ----- rtl/core/bmma_pkg.sv -----
// Shared types, widths and codes for the block matrix multiply-accumulate.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package bmma_pkg;

    localparam int MAX_BLOCK_DEF = 8;
    localparam int FRAC_BITS_DEF = 16;

    // Index fields between controller and datapath cover MAX_BLOCK up to 16.
    localparam int PKG_IDX_W = 4;

    localparam int ACTION_W   = 2;
    localparam int ROWCOL_W   = 3;
    localparam int VALUE_W    = 32;
    localparam int BS_W       = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [ACTION_W-1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOAD_C  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA = 1'd1;

    localparam logic [BS_W-1:0]    DIM_RST  = 4'd4;
    localparam logic [VALUE_W-1:0] BETA_RST = 32'd0;

    typedef struct packed {
        logic                 issue;
        logic                 beta_term;
        logic                 first;
        logic                 term_last;
        logic                 last_elem;
        logic [PKG_IDX_W-1:0] row;
        logic [PKG_IDX_W-1:0] col;
        logic [PKG_IDX_W-1:0] k;
        logic [VALUE_W-1:0]   beta;
        logic                 load_en;
        logic [ACTION_W-1:0]  ld_action;
        logic [ROWCOL_W-1:0]  ld_row;
        logic [ROWCOL_W-1:0]  ld_col;
        logic [VALUE_W-1:0]   ld_value;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic res_loaded;
    } t_dp_status;

endpackage

// ----- rtl/core/bmma_in_if.sv -----
// Input item channel: valid/ready handshake with one load or compute item per beat.
// Depends on bmma_pkg for the field widths.
`timescale 1ns / 1ps

interface bmma_in_if;
    logic                          valid;
    logic                          ready;
    logic [bmma_pkg::ACTION_W-1:0] action;
    logic [bmma_pkg::ROWCOL_W-1:0] row;
    logic [bmma_pkg::ROWCOL_W-1:0] col;
    logic [bmma_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output action, output row, output col, output value,
                    input ready);
    modport sink (input valid, input action, input row, input col, input value,
                  output ready);
endinterface

// ----- rtl/core/bmma_out_if.sv -----
// Result channel: valid/ready handshake with one result element per beat.
// Depends on bmma_pkg for the field widths.
`timescale 1ns / 1ps

interface bmma_out_if;
    logic                          valid;
    logic                          ready;
    logic [bmma_pkg::ROWCOL_W-1:0] out_row;
    logic [bmma_pkg::ROWCOL_W-1:0] out_col;
    logic [bmma_pkg::VALUE_W-1:0]  result;
    logic                          saturated;
    logic                          last;

    modport source (output valid, output out_row, output out_col, output result,
                    output saturated, output last, input ready);
    modport sink (input valid, input out_row, input out_col, input result,
                  input saturated, input last, output ready);
endinterface

// ----- rtl/core/bmma_cfg_if.sv -----
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on bmma_pkg for the field widths.
`timescale 1ns / 1ps

interface bmma_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bmma_pkg::CFG_IDX_W-1:0]  index;
    logic [bmma_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/bmma_ctrl.sv -----
// Controller: configuration registers, input handshake and the sequencer that walks
// result elements and their product terms. Depends on bmma_pkg and the channel interfaces.
`timescale 1ns / 1ps

module bmma_ctrl #(
    parameter int MAX_BLOCK = bmma_pkg::MAX_BLOCK_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bmma_cfg_if.sink             i_cfg,
    bmma_in_if.sink              i_in,
    output bmma_pkg::t_dp_cmd    o_cmd,
    input  bmma_pkg::t_dp_status i_status
);

    localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCK + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_ISSUE = 2'd2;
    localparam logic [1:0] S_WAIT  = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [IDX_W-1:0]             r_i, n_i;
    logic [IDX_W-1:0]             r_j, n_j;
    logic [IDX_W-1:0]             r_k, n_k;
    logic [CNT_W-1:0]             r_n, n_n;
    logic                         r_first, n_first;
    logic [bmma_pkg::BS_W-1:0]    r_dim;
    logic [bmma_pkg::VALUE_W-1:0] r_beta;

    logic             in_hs;
    logic [CNT_W-1:0] eff_n;
    logic [CNT_W-1:0] n_m1;
    logic             term_last;
    logic             elem_last;
    logic             row_end;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_hs       = i_in.valid && i_in.ready;

    assign eff_n = (5'(r_dim) > 5'(MAX_BLOCK)) ? CNT_W'(MAX_BLOCK)
                                               : CNT_W'(r_dim);
    assign n_m1      = r_n - CNT_W'(1);
    assign term_last = (CNT_W'(r_k) == n_m1);
    assign row_end   = (CNT_W'(r_j) == n_m1);
    assign elem_last = (CNT_W'(r_i) == n_m1) && row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim  <= bmma_pkg::DIM_RST;
            r_beta <= bmma_pkg::BETA_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                bmma_pkg::CFG_DIM: begin
                    r_dim <= i_cfg.data[bmma_pkg::BS_W-1:0];
                end
                bmma_pkg::CFG_BETA: begin
                    r_beta <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_n     = r_n;
        n_first = r_first;

        o_cmd           = '0;
        o_cmd.row       = bmma_pkg::PKG_IDX_W'(r_i);
        o_cmd.col       = bmma_pkg::PKG_IDX_W'(r_j);
        o_cmd.k         = bmma_pkg::PKG_IDX_W'(r_k);
        o_cmd.last_elem = elem_last;
        o_cmd.beta      = r_beta;
        o_cmd.load_en   = in_hs && (i_in.action != bmma_pkg::ACT_COMPUTE);
        o_cmd.ld_action = i_in.action;
        o_cmd.ld_row    = i_in.row;
        o_cmd.ld_col    = i_in.col;
        o_cmd.ld_value  = i_in.value;

        case (r_state)
            S_IDLE: begin
                if (in_hs && (i_in.action == bmma_pkg::ACT_COMPUTE) && (eff_n != '0)) begin
                    n_n     = eff_n;
                    n_i     = '0;
                    n_j     = '0;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_status.out_free) begin
                    n_k     = '0;
                    n_first = 1'b1;
                    if (r_beta != '0) begin
                        o_cmd.issue     = 1'b1;
                        o_cmd.beta_term = 1'b1;
                        o_cmd.first     = 1'b1;
                        n_first         = 1'b0;
                    end
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.issue     = 1'b1;
                o_cmd.first     = r_first;
                o_cmd.term_last = term_last;
                n_first         = 1'b0;
                n_k             = r_k + IDX_W'(1);
                if (term_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_status.res_loaded) begin
                    if (elem_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_START;
                        if (row_end) begin
                            n_j = '0;
                            n_i = r_i + IDX_W'(1);
                        end else begin
                            n_j = r_j + IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_n     <= '0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_n     <= n_n;
            r_first <= n_first;
        end
    end

endmodule

// ----- rtl/core/bmma_datapath.sv -----
// Datapath: element memories, multiply-accumulate pipeline, rounding and saturation,
// write-back into the accumulator matrix and the result register. Depends on bmma_pkg.
`timescale 1ns / 1ps

module bmma_datapath #(
    parameter int MAX_BLOCK = bmma_pkg::MAX_BLOCK_DEF,
    parameter int FRAC_BITS = bmma_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bmma_pkg::t_dp_cmd     i_cmd,
    output bmma_pkg::t_dp_status  o_status,
    bmma_out_if.source            o_out
);

    localparam int IDX_W  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int DEPTH  = MAX_BLOCK * MAX_BLOCK;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW     = bmma_pkg::VALUE_W;
    localparam int PROD_W = 2 * VW;
    localparam int ACC_W  = PROD_W + 1 + $clog2(MAX_BLOCK + 1);
    localparam logic [ACC_W-1:0] RND = ACC_W'(2 ** FRAC_BITS) >> 1;

    typedef struct packed {
        logic                           valid;
        logic                           beta_term;
        logic                           first;
        logic                           term_last;
        logic                           last_elem;
        logic [bmma_pkg::PKG_IDX_W-1:0] row;
        logic [bmma_pkg::PKG_IDX_W-1:0] col;
    } t_tag;

    logic [VW-1:0] mem_a [DEPTH];
    logic [VW-1:0] mem_b [DEPTH];
    logic [VW-1:0] mem_c [DEPTH];
    logic [DEPTH-1:0] r_c_vld;

    logic [VW-1:0]               r_a_rd, r_b_rd, r_c_rd;
    logic                        r_cv;
    t_tag                        r_t1, r_t2, r_t3;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;

    logic                        r_out_valid;
    logic [bmma_pkg::ROWCOL_W-1:0] r_out_row, r_out_col;
    logic [VW-1:0]               r_out_result;
    logic                        r_out_sat;
    logic                        r_out_last;

    logic [IDX_W-1:0]         ri, ci, ki, ld_ri, ld_ci, wb_ri, wb_ci;
    logic [AW-1:0]            a_addr, b_addr, c_addr, ld_addr, wb_addr;
    logic                     ld_ok;
    logic signed [VW-1:0]     op_a, op_b;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [ACC_W-1:0]  prod_ext, acc_base;
    logic signed [ACC_W-1:0]  rnd_sum, shifted;
    logic [ACC_W-32:0]        hi_bits;
    logic                     fits;
    logic [VW-1:0]            fin_result;
    logic                     finish;
    logic                     out_hs;

    function automatic logic [AW-1:0] f_addr(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
        return AW'(int'(r) * MAX_BLOCK + int'(c));
    endfunction

    assign ri      = i_cmd.row[IDX_W-1:0];
    assign ci      = i_cmd.col[IDX_W-1:0];
    assign ki      = i_cmd.k[IDX_W-1:0];
    assign a_addr  = f_addr(ri, ki);
    assign b_addr  = f_addr(ki, ci);
    assign c_addr  = f_addr(ri, ci);

    assign ld_ri   = IDX_W'(i_cmd.ld_row);
    assign ld_ci   = IDX_W'(i_cmd.ld_col);
    assign ld_addr = f_addr(ld_ri, ld_ci);
    assign ld_ok   = i_cmd.load_en && (5'(i_cmd.ld_row) < 5'(MAX_BLOCK))
                     && (5'(i_cmd.ld_col) < 5'(MAX_BLOCK));

    assign wb_ri   = r_t3.row[IDX_W-1:0];
    assign wb_ci   = r_t3.col[IDX_W-1:0];
    assign wb_addr = f_addr(wb_ri, wb_ci);

    assign finish  = r_t3.valid && r_t3.term_last;
    assign out_hs  = r_out_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (ld_ok && (i_cmd.ld_action == bmma_pkg::ACT_LOAD_A)) begin
            mem_a[ld_addr] <= i_cmd.ld_value;
        end
        if (ld_ok && (i_cmd.ld_action == bmma_pkg::ACT_LOAD_B)) begin
            mem_b[ld_addr] <= i_cmd.ld_value;
        end
        if (finish) begin
            mem_c[wb_addr] <= fin_result;
        end else if (ld_ok && (i_cmd.ld_action == bmma_pkg::ACT_LOAD_C)) begin
            mem_c[ld_addr] <= i_cmd.ld_value;
        end
        r_a_rd <= mem_a[a_addr];
        r_b_rd <= mem_b[b_addr];
        r_c_rd <= mem_c[c_addr];
        r_cv   <= r_c_vld[c_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= '0;
        end else if (finish) begin
            r_c_vld[wb_addr] <= 1'b1;
        end else if (ld_ok && (i_cmd.ld_action == bmma_pkg::ACT_LOAD_C)) begin
            r_c_vld[ld_addr] <= 1'b1;
        end
    end

    // A beta term multiplies beta by the old C; an entry never written reads as zero.
    assign op_a     = r_t1.beta_term ? $signed(i_cmd.beta) : $signed(r_a_rd);
    assign op_b     = r_t1.beta_term ? (r_cv ? $signed(r_c_rd) : '0) : $signed(r_b_rd);
    assign prod_c   = op_a * op_b;
    assign prod_ext = ACC_W'(r_prod);
    assign acc_base = r_t2.first ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= prod_c;
        if (r_t2.valid) begin
            r_acc <= acc_base + prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
        end else begin
            r_t1.valid     <= i_cmd.issue;
            r_t1.beta_term <= i_cmd.beta_term;
            r_t1.first     <= i_cmd.first;
            r_t1.term_last <= i_cmd.term_last;
            r_t1.last_elem <= i_cmd.last_elem;
            r_t1.row       <= i_cmd.row;
            r_t1.col       <= i_cmd.col;
            r_t2           <= r_t1;
            r_t3           <= r_t2;
        end
    end

    assign rnd_sum    = r_acc + $signed(RND);
    assign shifted    = rnd_sum >>> FRAC_BITS;
    assign hi_bits    = shifted[ACC_W-1:31];
    assign fits       = (&hi_bits) || !(|hi_bits);
    assign fin_result = fits ? shifted[VW-1:0]
                      : (shifted[ACC_W-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (out_hs) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_row    <= r_t3.row[bmma_pkg::ROWCOL_W-1:0];
            r_out_col    <= r_t3.col[bmma_pkg::ROWCOL_W-1:0];
            r_out_result <= fin_result;
            r_out_sat    <= !fits;
            r_out_last   <= r_t3.last_elem;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_row   = r_out_row;
    assign o_out.out_col   = r_out_col;
    assign o_out.result    = r_out_result;
    assign o_out.saturated = r_out_sat;
    assign o_out.last      = r_out_last;

    assign o_status.out_free   = !r_out_valid || o_out.ready;
    assign o_status.res_loaded = finish;

endmodule

// ----- rtl/core/block_matrix_multiply_accumulate_top.sv -----
// Top level of the block matrix multiply-accumulate C = A*B + beta*C.
// Instantiates bmma_ctrl and bmma_datapath; depends on bmma_pkg and the channel interfaces.
//
//  Channel  Port    Direction  Beat carries
//  config   i_cfg   in         index, data (block dimension, beta)
//  input    i_in    in         action, row, col, value
//  output   o_out   out        out_row, out_col, result, saturated, last
//
// Loads are accepted only while idle. A compute with n = min(dimension, MAX_BLOCK) keeps
// the input not ready until its last element is written back: per result element a start
// step that also issues the beta*C product when beta is nonzero, n product terms on the
// single 32x32 multiplier, then the read, multiply and accumulate registers and rounding.
// Reset clears control state, pipeline tags and valid bits and sets dimension 4, beta 0.
// A stalled output holds the next element from starting; config is always ready.
`timescale 1ns / 1ps

module block_matrix_multiply_accumulate_top #(
    parameter int MAX_BLOCK = bmma_pkg::MAX_BLOCK_DEF,
    parameter int FRAC_BITS = bmma_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bmma_cfg_if.sink    i_cfg,
    bmma_in_if.sink     i_in,
    bmma_out_if.source  o_out
);

    bmma_pkg::t_dp_cmd    cmd;
    bmma_pkg::t_dp_status status;

    bmma_ctrl #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_in     (i_in),
        .o_cmd    (cmd),
        .i_status (status)
    );

    bmma_datapath #(
        .MAX_BLOCK (MAX_BLOCK),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .o_out    (o_out)
    );

endmodule

// ----- sim/block_matrix_multiply_accumulate_top_test.sv -----
// Self-checking testbench for block_matrix_multiply_accumulate_top: a directed table, then
// random load and compute beats under several idle patterns, checked against a predictor.
// Depends on bmma_pkg, the three channel interfaces and the top level.
`timescale 1ns / 1ps

module block_matrix_multiply_accumulate_top_test;
    import bmma_pkg::*;

    localparam int MAXB          = MAX_BLOCK_DEF;
    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int QUIET_CYCLES  = 20;
    localparam int STALL_LIMIT   = 3000;
    localparam int PHASE_ITEMS   = 6;
    localparam int NUM_PHASES    = 8;
    localparam int NUM_DIRECTED  = 26;

    localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (FRAC - 1);
    localparam logic signed [127:0] RES_MAX    = 128'sd2147483647;
    localparam logic signed [127:0] RES_MIN    = -128'sd2147483648;

    typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} t_pace;

    typedef struct packed {
        logic [ROWCOL_W-1:0] out_row;
        logic [ROWCOL_W-1:0] out_col;
        logic [VALUE_W-1:0]  result;
        logic                saturated;
        logic                last;
    } t_elem;

    // On a configuration row the value column holds beta.
    typedef struct packed {
        logic                is_cfg;
        logic [ACTION_W-1:0] action;
        logic [ROWCOL_W-1:0] row;
        logic [ROWCOL_W-1:0] col;
        logic [VALUE_W-1:0]  value;
        logic [BS_W-1:0]     size;
        logic                typed;
        logic [VALUE_W-1:0]  want_res;
        logic                want_sat;
    } t_dir_step;

    localparam t_dir_step DIRECTED [NUM_DIRECTED] = '{
        '{1'b1, ACT_LOAD_A,  3'd0, 3'd0, 32'h0,        4'd1, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_LOAD_A,  3'd0, 3'd0, 32'h00010000, 4'd0, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_LOAD_B,  3'd0, 3'd0, 32'h00020000, 4'd0, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_COMPUTE, 3'd0, 3'd0, 32'h0,        4'd0, 1'b1, 32'h00020000, 1'b0},
        '{1'b1, ACT_LOAD_A,  3'd0, 3'd0, 32'h00010000, 4'd1, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_COMPUTE, 3'd0, 3'd0, 32'h0,        4'd0, 1'b1, 32'h00040000, 1'b0},
        '{1'b0, ACT_LOAD_A,  3'd0, 3'd0, 32'h7FFFFFFF, 4'd0, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_LOAD_B,  3'd0, 3'd0, 32'h7FFFFFFF, 4'd0, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_COMPUTE, 3'd0, 3'd0, 32'h0,        4'd0, 1'b1, 32'h7FFFFFFF, 1'b1},
        '{1'b0, ACT_LOAD_A,  3'd0, 3'd0, 32'h80000000, 4'd0, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_COMPUTE, 3'd0, 3'd0, 32'h0,        4'd0, 1'b1, 32'h80000000, 1'b1},
        '{1'b0, ACT_LOAD_B,  3'd0, 3'd0, 32'h80000000, 4'd0, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_COMPUTE, 3'd0, 3'd0, 32'h0,        4'd0, 1'b1, 32'h7FFFFFFF, 1'b1},
        '{1'b1, ACT_LOAD_A,  3'd0, 3'd0, 32'h0,        4'd1, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_LOAD_A,  3'd0, 3'd0, 32'h00000001, 4'd0, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_LOAD_B,  3'd0, 3'd0, 32'h00008000, 4'd0, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_COMPUTE, 3'd0, 3'd0, 32'hFFFFFFFF, 4'd0, 1'b1, 32'h00000001, 1'b0},
        '{1'b0, ACT_LOAD_A,  3'd0, 3'd0, 32'hFFFFFFFF, 4'd0, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_COMPUTE, 3'd0, 3'd0, 32'h0,        4'd0, 1'b1, 32'h00000000, 1'b0},
        '{1'b0, ACT_LOAD_C,  3'd7, 3'd7, 32'h12345678, 4'd0, 1'b0, 32'h0,        1'b0},
        '{1'b1, ACT_LOAD_A,  3'd0, 3'd0, 32'h80000000, 4'd0, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_COMPUTE, 3'd0, 3'd0, 32'h0,        4'd0, 1'b0, 32'h0,        1'b0},
        '{1'b1, ACT_LOAD_A,  3'd0, 3'd0, 32'h80000000, 4'd2, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_COMPUTE, 3'd0, 3'd0, 32'h0,        4'd0, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_LOAD_C,  3'd1, 3'd1, 32'h7FFFFFFF, 4'd0, 1'b0, 32'h0,        1'b0},
        '{1'b0, ACT_COMPUTE, 3'd0, 3'd0, 32'h0,        4'd0, 1'b0, 32'h0,        1'b0}
    };

    localparam logic [BS_W-1:0] PHASE_SIZE [NUM_PHASES] = '{
        4'd3, 4'd2, 4'd15, 4'd1, 4'd8, 4'd0, 4'd2, 4'd3
    };
    localparam logic [VALUE_W-1:0] PHASE_BETA [NUM_PHASES] = '{
        32'h00010000, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFF0000, 32'h00008000, 32'h0, 32'h0
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    bmma_cfg_if reg_ch ();
    bmma_in_if  item_ch ();
    bmma_out_if result_ch ();

    block_matrix_multiply_accumulate_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (reg_ch),
        .i_in    (item_ch),
        .o_out   (result_ch)
    );

    always #6 i_clk = ~i_clk;

    logic signed [VALUE_W-1:0] lhs_mem [MAXB*MAXB];
    logic signed [VALUE_W-1:0] rhs_mem [MAXB*MAXB];
    logic signed [VALUE_W-1:0] acc_mem [MAXB*MAXB];
    bit                        lhs_set [MAXB*MAXB];
    bit                        rhs_set [MAXB*MAXB];
    logic [BS_W-1:0]           cur_size;
    logic signed [VALUE_W-1:0] cur_beta;

    t_elem pending_elems [$];
    t_elem fresh_elems [$];
    int    mismatch_count = 0;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    int    stall_cycles   = 0;
    int    phase_sent;

    function automatic int active_size();
        return (cur_size > MAXB) ? MAXB : int'(cur_size);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2, 3: return $urandom;
            default: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
        endcase
    endfunction

    // Updates the local matrices and fills fresh_elems with what a compute emits.
    task automatic apply_item(input logic [ACTION_W-1:0] act, input logic [ROWCOL_W-1:0] r,
                              input logic [ROWCOL_W-1:0] c, input logic [VALUE_W-1:0] v);
        int n;
        int at;
        logic signed [127:0] sum;
        logic signed [63:0]  prod;
        t_elem e;
        fresh_elems.delete();
        at = int'(r) * MAXB + int'(c);
        case (act)
            ACT_LOAD_A: begin
                lhs_mem[at] = v;
                lhs_set[at] = 1'b1;
            end
            ACT_LOAD_B: begin
                rhs_mem[at] = v;
                rhs_set[at] = 1'b1;
            end
            ACT_LOAD_C: acc_mem[at] = v;
            default: begin
                n = active_size();
                for (int i = 0; i < n; i++) begin
                    for (int j = 0; j < n; j++) begin
                        at  = i * MAXB + j;
                        sum = '0;
                        if (cur_beta != 0) begin
                            prod = cur_beta * acc_mem[at];
                            sum  = sum + prod;
                        end
                        for (int k = 0; k < n; k++) begin
                            prod = lhs_mem[i*MAXB + k] * rhs_mem[k*MAXB + j];
                            sum  = sum + prod;
                        end
                        sum = (sum + ROUND_HALF) >>> FRAC;
                        e.out_row = ROWCOL_W'(i);
                        e.out_col = ROWCOL_W'(j);
                        if (sum > RES_MAX) begin
                            e.result    = 32'h7FFFFFFF;
                            e.saturated = 1'b1;
                        end else if (sum < RES_MIN) begin
                            e.result    = 32'h80000000;
                            e.saturated = 1'b1;
                        end else begin
                            e.result    = sum[VALUE_W-1:0];
                            e.saturated = 1'b0;
                        end
                        e.last = (i == n - 1) && (j == n - 1);
                        acc_mem[at] = e.result;
                        fresh_elems.push_back(e);
                    end
                end
            end
        endcase
    endtask

    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [ROWCOL_W-1:0] r,
                             input logic [ROWCOL_W-1:0] c, input logic [VALUE_W-1:0] v,
                             input logic typed, input logic [VALUE_W-1:0] want_res,
                             input logic want_sat);
        t_elem e;
        if ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        item_ch.valid  <= 1'b1;
        item_ch.action <= act;
        item_ch.row    <= r;
        item_ch.col    <= c;
        item_ch.value  <= v;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        apply_item(act, r, c, v);
        if (typed) begin
            e.out_row   = '0;
            e.out_col   = '0;
            e.result    = want_res;
            e.saturated = want_sat;
            e.last      = 1'b1;
            pending_elems.push_back(e);
        end else begin
            foreach (fresh_elems[i]) pending_elems.push_back(fresh_elems[i]);
        end
        phase_sent++;
    endtask

    // Every A and B entry that a compute reads is loaded first.
    task automatic run_compute(input logic [VALUE_W-1:0] v);
        int n;
        n = active_size();
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if (!lhs_set[i*MAXB + j])
                    send_item(ACT_LOAD_A, 3'(i), 3'(j), rand_value(), 1'b0, '0, 1'b0);
                if (!rhs_set[i*MAXB + j])
                    send_item(ACT_LOAD_B, 3'(i), 3'(j), rand_value(), 1'b0, '0, 1'b0);
            end
        end
        send_item(ACT_COMPUTE, 3'($urandom), 3'($urandom), v, 1'b0, '0, 1'b0);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending_elems.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [BS_W-1:0] size, input logic [VALUE_W-1:0] beta_val);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= CFG_DIM;
        reg_ch.data  <= CFG_DATA_W'(size);
        do @(posedge i_clk); while (reg_ch.ready !== 1'b1);
        cur_size     = size;
        reg_ch.index <= CFG_BETA;
        reg_ch.data  <= beta_val;
        do @(posedge i_clk); while (reg_ch.ready !== 1'b1);
        cur_beta     = beta_val;
        reg_ch.valid <= 1'b0;
    endtask

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_FREE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            PACE_SEND_IDLE: begin
                send_idle_pct  = 72;
                recv_stall_pct = 0;
            end
            PACE_RECV_STALL: begin
                send_idle_pct  = 0;
                recv_stall_pct = 72;
            end
            default: begin
                send_idle_pct  = 20;
                recv_stall_pct = 20;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_elem want;
        if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (pending_elems.size() == 0) begin
                $error("result beat with no expectation: row %0d col %0d result %0h",
                       result_ch.out_row, result_ch.out_col, result_ch.result);
                mismatch_count++;
            end else begin
                want = pending_elems.pop_front();
                check_field("out_row", 32'(want.out_row), 32'(result_ch.out_row));
                check_field("out_col", 32'(want.out_col), 32'(result_ch.out_col));
                check_field("result", want.result, result_ch.result);
                check_field("saturated", 32'(want.saturated), 32'(result_ch.saturated));
                check_field("last", 32'(want.last), 32'(result_ch.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
            (reg_ch.valid === 1'b1 && reg_ch.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int n;
        int lim;
        logic [BS_W-1:0]    size;
        logic [VALUE_W-1:0] beta_val;
        i_rst_n         <= 1'b0;
        reg_ch.valid    <= 1'b0;
        reg_ch.index    <= CFG_DIM;
        reg_ch.data     <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.action  <= ACT_LOAD_A;
        item_ch.row     <= '0;
        item_ch.col     <= '0;
        item_ch.value   <= '0;
        for (int i = 0; i < MAXB * MAXB; i++) begin
            lhs_mem[i] = '0;
            rhs_mem[i] = '0;
            acc_mem[i] = '0;
        end
        cur_size = DIM_RST;
        cur_beta = BETA_RST;
        set_pace(PACE_FREE);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int s = 0; s < NUM_DIRECTED; s++) begin
            if (DIRECTED[s].is_cfg) begin
                drain();
                write_regs(DIRECTED[s].size, DIRECTED[s].value);
            end else if (DIRECTED[s].action == ACT_COMPUTE && !DIRECTED[s].typed) begin
                run_compute(DIRECTED[s].value);
            end else begin
                send_item(DIRECTED[s].action, DIRECTED[s].row, DIRECTED[s].col,
                          DIRECTED[s].value, DIRECTED[s].typed, DIRECTED[s].want_res,
                          DIRECTED[s].want_sat);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            size     = PHASE_SIZE[ph];
            beta_val = PHASE_BETA[ph];
            if (ph >= NUM_PHASES - 2) begin
                size     = BS_W'($urandom_range(1, 4));
                beta_val = (ph == NUM_PHASES - 1) ? rand_value() : $urandom;
            end
            write_regs(size, beta_val);
            set_pace(t_pace'(ph % 4));
            phase_sent = 0;
            n   = active_size();
            lim = (n == 0) ? MAXB - 1 : n - 1;
            while (phase_sent < PHASE_ITEMS) begin
                if ($urandom_range(99) < 70) begin
                    repeat ($urandom_range(1, 6))
                        send_item(ACTION_W'($urandom_range(0, 2)), 3'($urandom_range(lim)),
                                  3'($urandom_range(lim)), rand_value(), 1'b0, '0, 1'b0);
                    run_compute($urandom);
                end else begin
                    if ($urandom_range(3) == 0)
                        run_compute($urandom);
                    else
                        send_item(ACTION_W'($urandom_range(0, 2)), 3'($urandom),
                                  3'($urandom), rand_value(), 1'b0, '0, 1'b0);
                end
            end
        end

        drain();
        if (mismatch_count == 0 && pending_elems.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- block_matrix_multiply_accumulate_top.f -----
rtl/core/bmma_pkg.sv
rtl/core/bmma_in_if.sv
rtl/core/bmma_out_if.sv
rtl/core/bmma_cfg_if.sv
rtl/core/bmma_ctrl.sv
rtl/core/bmma_datapath.sv
rtl/core/block_matrix_multiply_accumulate_top.sv
sim/block_matrix_multiply_accumulate_top_test.sv
